>>> hdl/bc3_pkg.sv
// bc3_pkg: shared types and constants for the bc3 block decoder
// the front, queue, back and top-level modules import this package
`timescale 1ns / 1ps
`default_nettype none

package bc3_pkg;

    localparam int COORD_W                = 11;
    localparam int DEFAULT_MAX_IMAGE_SIDE = 2048;
    localparam int QUEUE_DEPTH            = 2;
    localparam int PIXELS                 = 16;
    localparam int PIX_W                  = 4;

    // one compressed block with its position
    typedef struct packed {
        logic [7:0]  alpha_end0;
        logic [7:0]  alpha_end1;
        logic [47:0] alpha_indices;
        logic [15:0] color_end0;
        logic [15:0] color_end1;
        logic [31:0] color_indices;
        logic [8:0]  block_column;
        logic [8:0]  block_row;
    } bc3_in_t;

    // one decoded pixel
    typedef struct packed {
        logic [COORD_W-1:0] pixel_x;
        logic [COORD_W-1:0] pixel_y;
        logic [31:0]        argb;
        logic               last;
    } bc3_out_t;

    // front pipeline: weighted endpoint sums, before the constant divides
    typedef struct packed {
        logic                     gt;
        logic [7:0]               a0;
        logic [7:0]               a1;
        logic [5:0][10:0]         alpha_sum;
        logic [2:0][7:0]          e0;
        logic [2:0][7:0]          e1;
        logic [2:0][9:0]          c2_sum;
        logic [2:0][9:0]          c3_sum;
        logic [15:0][2:0]         alpha_sel;
        logic [15:0][1:0]         color_sel;
        logic [COORD_W-1:0]       vx;
        logic [COORD_W-1:0]       vy;
        logic [COORD_W-1:0]       qx;
        logic [COORD_W-1:0]       qy;
    } bc3_sum_t;

    // decoded palettes of one block, as held in the queue
    typedef struct packed {
        logic [7:0][7:0]          alpha_pal;
        logic [3:0][2:0][7:0]     color_pal;
        logic [15:0][2:0]         alpha_sel;
        logic [15:0][1:0]         color_sel;
        logic [COORD_W-1:0]       x_base;
        logic [COORD_W-1:0]       y_base;
    } bc3_blk_t;

endpackage

`default_nettype wire

>>> hdl/bc3_front.sv
// bc3_front: two-stage block pipeline that builds the alpha and colour palettes
// and the wrapped block origin; depends on bc3_pkg, feeds bc3_queue
`timescale 1ns / 1ps
`default_nettype none

module bc3_front
    import bc3_pkg::*;
#(
    parameter int MAX_IMAGE_SIDE = DEFAULT_MAX_IMAGE_SIDE
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     blk_valid,
    output logic          blk_stall,
    input  wire bc3_in_t  blk_data,
    output logic          q_push,
    input  wire logic     q_ready,
    output bc3_blk_t      q_data
);

    // reciprocal for coordinate reduction, exact for all 11-bit values
    localparam int CSHIFT = COORD_W + $clog2(MAX_IMAGE_SIDE);
    localparam int CRECIP = ((2 ** CSHIFT) + MAX_IMAGE_SIDE - 1) / MAX_IMAGE_SIDE;
    localparam int PW     = 26;

    localparam int        DSHIFT   = 16;
    localparam logic [24:0] RECIP7 = 25'd9363;
    localparam logic [24:0] RECIP5 = 25'd13108;
    localparam logic [24:0] RECIP3 = 25'd21846;
    localparam logic [7:0]  ALPHA_MIN = 8'd0;
    localparam logic [7:0]  ALPHA_MAX = 8'd255;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    function automatic logic [7:0] div_recip(input logic [10:0] s, input logic [24:0] r);
        logic [24:0] p;
        p = 25'(s) * r;
        return 8'(p >> DSHIFT);
    endfunction

    logic     a_valid_reg, a_valid_next;
    bc3_in_t  a_reg;
    logic     b_valid_reg, b_valid_next;
    bc3_sum_t b_reg;
    bc3_sum_t sum_next;
    logic     a_move, b_move;

    assign b_move    = !b_valid_reg || q_ready;
    assign a_move    = !a_valid_reg || b_move;
    assign blk_stall = !a_move;
    assign q_push    = b_valid_reg;

    assign a_valid_next = a_move ? blk_valid : a_valid_reg;
    assign b_valid_next = b_move ? a_valid_reg : b_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_move && blk_valid)
            a_reg <= blk_data;
        if (b_move && a_valid_reg)
            b_reg <= sum_next;
    end

    // stage a: expand endpoints, weighted sums, coordinate quotients
    always_comb
    begin
        logic [PW-1:0] px;
        logic [PW-1:0] py;
        sum_next.a0 = a_reg.alpha_end0;
        sum_next.a1 = a_reg.alpha_end1;
        sum_next.gt = a_reg.alpha_end0 > a_reg.alpha_end1;
        for (int i = 1; i <= 6; i++)
        begin
            if (sum_next.gt)
                sum_next.alpha_sum[i-1] = 11'(a_reg.alpha_end0 * (7 - i))
                                        + 11'(a_reg.alpha_end1 * i);
            else if (i <= 4)
                sum_next.alpha_sum[i-1] = 11'(a_reg.alpha_end0 * (5 - i))
                                        + 11'(a_reg.alpha_end1 * i);
            else
                sum_next.alpha_sum[i-1] = '0;
        end

        sum_next.e0 = {expand5(a_reg.color_end0[15:11]), expand6(a_reg.color_end0[10:5]),
                       expand5(a_reg.color_end0[4:0])};
        sum_next.e1 = {expand5(a_reg.color_end1[15:11]), expand6(a_reg.color_end1[10:5]),
                       expand5(a_reg.color_end1[4:0])};
        for (int ch = 0; ch < 3; ch++)
        begin
            sum_next.c2_sum[ch] = 10'({sum_next.e0[ch], 1'b0}) + 10'(sum_next.e1[ch]);
            sum_next.c3_sum[ch] = 10'(sum_next.e0[ch]) + 10'({sum_next.e1[ch], 1'b0});
        end

        sum_next.alpha_sel = a_reg.alpha_indices;
        sum_next.color_sel = a_reg.color_indices;

        sum_next.vx = {a_reg.block_column, 2'b00};
        sum_next.vy = {a_reg.block_row, 2'b00};
        px = PW'(sum_next.vx) * PW'(CRECIP);
        py = PW'(sum_next.vy) * PW'(CRECIP);
        sum_next.qx = COORD_W'(px >> CSHIFT);
        sum_next.qy = COORD_W'(py >> CSHIFT);
    end

    // stage b: constant divides by reciprocal, coordinate remainders
    always_comb
    begin
        q_data.alpha_pal[0] = b_reg.a0;
        q_data.alpha_pal[1] = b_reg.a1;
        for (int i = 1; i <= 6; i++)
        begin
            if (b_reg.gt)
                q_data.alpha_pal[i+1] = div_recip(b_reg.alpha_sum[i-1], RECIP7);
            else if (i <= 4)
                q_data.alpha_pal[i+1] = div_recip(b_reg.alpha_sum[i-1], RECIP5);
            else if (i == 5)
                q_data.alpha_pal[i+1] = ALPHA_MIN;
            else
                q_data.alpha_pal[i+1] = ALPHA_MAX;
        end

        q_data.color_pal[0] = b_reg.e0;
        q_data.color_pal[1] = b_reg.e1;
        for (int ch = 0; ch < 3; ch++)
        begin
            q_data.color_pal[2][ch] = div_recip(11'(b_reg.c2_sum[ch]), RECIP3);
            q_data.color_pal[3][ch] = div_recip(11'(b_reg.c3_sum[ch]), RECIP3);
        end

        q_data.alpha_sel = b_reg.alpha_sel;
        q_data.color_sel = b_reg.color_sel;
        q_data.x_base = COORD_W'(PW'(b_reg.vx) - PW'(b_reg.qx) * PW'(MAX_IMAGE_SIDE));
        q_data.y_base = COORD_W'(PW'(b_reg.vy) - PW'(b_reg.qy) * PW'(MAX_IMAGE_SIDE));
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        blk_stall |-> a_valid_reg && b_valid_reg && !q_ready)
        else $error("front stalls with room in the pipeline");

    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && !q_ready |=> b_valid_reg && $stable(b_reg))
        else $error("stage b lost or changed a block while the queue was full");

endmodule

`default_nettype wire

>>> hdl/bc3_queue.sv
// bc3_queue: short fifo of decoded palettes between front and back
// depends on bc3_pkg for the entry type and depth
`timescale 1ns / 1ps
`default_nettype none

module bc3_queue
    import bc3_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     wr_valid,
    output logic          wr_ready,
    input  wire bc3_blk_t wr_data,
    output logic          rd_valid,
    input  wire logic     rd_pop,
    output bc3_blk_t      rd_data
);

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    bc3_blk_t        slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push, pop;

    assign wr_ready = count_reg != CW'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_pop && rd_valid;
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg != '0)
        else $error("queue empty right after a write");

endmodule

`default_nettype wire

>>> hdl/bc3_back.sv
// bc3_back: walks the head block's 16 pixels, one per unstalled cycle,
// into the registered pixel output; depends on bc3_pkg, reads bc3_queue
`timescale 1ns / 1ps
`default_nettype none

module bc3_back
    import bc3_pkg::*;
#(
    parameter int MAX_IMAGE_SIDE = DEFAULT_MAX_IMAGE_SIDE
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     q_valid,
    output logic          q_pop,
    input  wire bc3_blk_t q_data,
    output logic          pix_valid,
    input  wire logic     pix_stall,
    output bc3_out_t      pix_data
);

    localparam int SW = $clog2(MAX_IMAGE_SIDE) + 1;
    localparam int XW = (SW > COORD_W + 1) ? SW : COORD_W + 1;
    localparam logic [PIX_W-1:0] LAST_PIX = PIX_W'(PIXELS - 1);

    logic              pix_valid_reg, pix_valid_next;
    bc3_out_t          pix_reg, pix_next;
    logic [PIX_W-1:0]  cnt_reg, cnt_next;
    logic              load;
    logic [XW-1:0]     x_sum, y_sum;
    logic [2:0]        ai;
    logic [1:0]        ci;

    assign load      = q_valid && (!pix_valid_reg || !pix_stall);
    assign q_pop     = load && cnt_reg == LAST_PIX;
    assign pix_valid = pix_valid_reg;
    assign pix_data  = pix_reg;

    always_comb
    begin
        ai = q_data.alpha_sel[cnt_reg];
        ci = q_data.color_sel[cnt_reg];

        // origin is already below the side, one subtract wraps the offset
        x_sum = XW'(q_data.x_base) + XW'(cnt_reg[1:0]);
        y_sum = XW'(q_data.y_base) + XW'(cnt_reg[3:2]);
        if (x_sum >= XW'(MAX_IMAGE_SIDE))
            x_sum = x_sum - XW'(MAX_IMAGE_SIDE);
        if (y_sum >= XW'(MAX_IMAGE_SIDE))
            y_sum = y_sum - XW'(MAX_IMAGE_SIDE);

        pix_next.pixel_x = COORD_W'(x_sum);
        pix_next.pixel_y = COORD_W'(y_sum);
        pix_next.argb    = {q_data.alpha_pal[ai], q_data.color_pal[ci]};
        pix_next.last    = cnt_reg == LAST_PIX;

        cnt_next = load ? cnt_reg + 1'b1 : cnt_reg;
        if (load)
            pix_valid_next = 1'b1;
        else
            pix_valid_next = pix_valid_reg && pix_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            pix_valid_reg <= pix_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            pix_reg <= pix_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != '0 |-> q_valid)
        else $error("block left the queue before its last pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid_reg && pix_reg.last |-> cnt_reg == '0)
        else $error("pixel counter not rewound after the last pixel");

endmodule

`default_nettype wire

>>> hdl/bc3_block_decoder.sv
// bc3_block_decoder: top level of the bc3 (dxt5) block decoder
// instantiates bc3_front, bc3_queue and bc3_back; depends on bc3_pkg
//
//   channel  dir  payload    per request
//   blk      in   bc3_in_t   one 16-byte block with its block column and row
//   pix      out  bc3_out_t  one argb8888 pixel with coordinates, last on the 16th
//
// sustained rate is set by the back end's pixel counter, which sends one pixel
// per cycle from the head of the queue while pix is not stalled. a block taken
// on blk passes the stage a and b registers and a queue slot before its first
// pixel is registered on pix. reset clears valid flags, queue pointers and
// count, and the pixel counter only. a stall on pix freezes the output; blk
// keeps taking blocks until both front stages and the two-entry queue are full.
`timescale 1ns / 1ps
`default_nettype none

module bc3_block_decoder
    import bc3_pkg::*;
#(
    parameter int MAX_IMAGE_SIDE = DEFAULT_MAX_IMAGE_SIDE
)(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    blk_valid,
    output logic         blk_stall,
    input  wire bc3_in_t blk_data,
    output logic         pix_valid,
    input  wire logic    pix_stall,
    output bc3_out_t     pix_data
);

    logic     push, push_ready;
    bc3_blk_t push_data;
    logic     head_valid, head_pop;
    bc3_blk_t head_data;

    bc3_front #(
        .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_valid (blk_valid),
        .blk_stall (blk_stall),
        .blk_data  (blk_data),
        .q_push    (push),
        .q_ready   (push_ready),
        .q_data    (push_data)
    );

    bc3_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (push),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (head_valid),
        .rd_pop   (head_pop),
        .rd_data  (head_data)
    );

    bc3_back #(
        .MAX_IMAGE_SIDE (MAX_IMAGE_SIDE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (head_valid),
        .q_pop     (head_pop),
        .q_data    (head_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data)
    );

endmodule

`default_nettype wire

>>> test/bc3_block_decoder_tb.sv
// bc3_block_decoder_tb: self-checking bench for the bc3 (dxt5) block decoder
// drives blocks through a directed table and random phases, checks every pixel
// against an in-bench palette decoder; depends on bc3_pkg and bc3_block_decoder
`timescale 1ns / 1ps

module bc3_block_decoder_tb;
    import bc3_pkg::*;

    localparam int IDLE_LIMIT  = 1000;
    localparam int HOLD_CYCLES = 100;

    typedef struct {
        bc3_in_t     blk;
        bit          fixed;
        logic [31:0] argb;
    } dir_row_t;

    logic     clk;
    logic     rst_n;
    logic     blk_valid;
    logic     blk_stall;
    bc3_in_t  blk_data;
    logic     pix_valid;
    logic     pix_stall;
    bc3_out_t pix_data;

    bc3_out_t    pixel_q[$];
    dir_row_t    dir_rows[$];
    int          errors;
    int          idle_cycles;
    bit          send_idle;
    bit          recv_idle;
    bit          hold_req;
    bit          cur_fixed;
    logic [31:0] cur_argb;

    bc3_block_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .blk_valid (blk_valid),
        .blk_stall (blk_stall),
        .blk_data  (blk_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data)
    );

    always #10 clk = ~clk;

    function automatic int expand5(int v);
        v = v & 31;
        return (v << 3) | (v >> 2);
    endfunction

    function automatic int expand6(int v);
        v = v & 63;
        return (v << 2) | (v >> 4);
    endfunction

    // decode one block into its sixteen pixels; a fixed row forces the argb value
    function automatic void push_decoded_pixels(bc3_in_t b, bit fixed, logic [31:0] argb);
        int       a0;
        int       a1;
        int       apal[8];
        int       cpal[4][3];
        int       asel;
        int       csel;
        bc3_out_t px;
        a0 = int'(b.alpha_end0);
        a1 = int'(b.alpha_end1);
        apal[0] = a0;
        apal[1] = a1;
        if (a0 > a1)
        begin
            for (int k = 1; k <= 6; k++)
                apal[k + 1] = ((7 - k) * a0 + k * a1) / 7;
        end
        else
        begin
            for (int k = 1; k <= 4; k++)
                apal[k + 1] = ((5 - k) * a0 + k * a1) / 5;
            apal[6] = 0;
            apal[7] = 255;
        end
        cpal[0][0] = expand5(int'(b.color_end0 >> 11));
        cpal[0][1] = expand6(int'(b.color_end0 >> 5));
        cpal[0][2] = expand5(int'(b.color_end0));
        cpal[1][0] = expand5(int'(b.color_end1 >> 11));
        cpal[1][1] = expand6(int'(b.color_end1 >> 5));
        cpal[1][2] = expand5(int'(b.color_end1));
        for (int ch = 0; ch < 3; ch++)
        begin
            cpal[2][ch] = (2 * cpal[0][ch] + cpal[1][ch]) / 3;
            cpal[3][ch] = (cpal[0][ch] + 2 * cpal[1][ch]) / 3;
        end
        for (int i = 0; i < PIXELS; i++)
        begin
            asel = int'(b.alpha_indices[3*i +: 3]);
            csel = int'(b.color_indices[2*i +: 2]);
            px.pixel_x = COORD_W'((b.block_column * 4 + (i & 3)) % DEFAULT_MAX_IMAGE_SIDE);
            px.pixel_y = COORD_W'((b.block_row * 4 + (i >> 2)) % DEFAULT_MAX_IMAGE_SIDE);
            if (fixed)
                px.argb = argb;
            else
                px.argb = {apal[asel][7:0], cpal[csel][0][7:0], cpal[csel][1][7:0],
                           cpal[csel][2][7:0]};
            px.last = (i == PIXELS - 1);
            pixel_q = {pixel_q, px};
        end
    endfunction

    function automatic void add_row(logic [7:0] a0, logic [7:0] a1, logic [47:0] ai,
                                    logic [15:0] c0, logic [15:0] c1, logic [31:0] ci,
                                    logic [8:0] col, logic [8:0] row,
                                    bit fixed, logic [31:0] argb);
        dir_row_t r;
        r.blk   = '{a0, a1, ai, c0, c1, ci, col, row};
        r.fixed = fixed;
        r.argb  = argb;
        dir_rows = {dir_rows, r};
    endfunction

    function automatic bc3_in_t random_block();
        bc3_in_t b;
        b.alpha_indices = 48'({$urandom, $urandom});
        b.color_indices = $urandom;
        b.color_end0    = 16'($urandom);
        b.color_end1    = 16'($urandom);
        b.alpha_end0    = 8'($urandom);
        // equal endpoints and near misses get extra weight
        case ($urandom_range(0, 5))
            0:       b.alpha_end1 = b.alpha_end0;
            1:       b.alpha_end1 = b.alpha_end0 + 8'd1;
            2:       b.alpha_end1 = b.alpha_end0 - 8'd1;
            default: b.alpha_end1 = 8'($urandom);
        endcase
        if ($urandom_range(0, 7) == 0)
            b.color_end1 = b.color_end0;
        b.block_column = 9'($urandom);
        b.block_row    = 9'($urandom);
        return b;
    endfunction

    // request on blk: optional gap, then hold valid until taken
    task automatic send_block(bc3_in_t b, bit fixed, logic [31:0] argb);
        int gap;
        if (send_idle && $urandom_range(0, 3) == 0)
        begin
            blk_valid <= 1'b0;
            gap = $urandom_range(1, 5);
            repeat (gap) @(negedge clk);
        end
        cur_fixed = fixed;
        cur_argb  = argb;
        blk_data  <= b;
        blk_valid <= 1'b1;
        do @(posedge clk); while (blk_stall);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pixel_q.size() != 0)
            @(posedge clk);
    endtask

    // receiver: random stall bursts, and one long hold on request
    initial
    begin
        int burst;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                pix_stall <= 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
                pix_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else if (recv_idle && $urandom_range(0, 2) == 0)
            begin
                pix_stall <= 1'b1;
                burst = $urandom_range(1, 5);
                repeat (burst) @(negedge clk);
                pix_stall <= 1'b0;
            end
        end
    end

    // monitor: predict on each accepted block, check each accepted pixel
    always @(posedge clk)
    begin
        bc3_out_t want;
        bit       moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (blk_valid && !blk_stall)
            begin
                push_decoded_pixels(blk_data, cur_fixed, cur_argb);
                moved = 1'b1;
            end
            if (pix_valid && !pix_stall)
            begin
                moved = 1'b1;
                if (pixel_q.size() == 0)
                begin
                    $error("pixel with no block pending: x=%0d y=%0d argb=%08h",
                           pix_data.pixel_x, pix_data.pixel_y, pix_data.argb);
                    errors++;
                end
                else
                begin
                    want = pixel_q.pop_front();
                    if (pix_data.pixel_x !== want.pixel_x)
                    begin
                        $error("pixel_x: expected %0d, got %0d", want.pixel_x, pix_data.pixel_x);
                        errors++;
                    end
                    if (pix_data.pixel_y !== want.pixel_y)
                    begin
                        $error("pixel_y: expected %0d, got %0d", want.pixel_y, pix_data.pixel_y);
                        errors++;
                    end
                    if (pix_data.argb !== want.argb)
                    begin
                        $error("argb: expected %08h, got %08h", want.argb, pix_data.argb);
                        errors++;
                    end
                    if (pix_data.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, pix_data.last);
                        errors++;
                    end
                end
            end
        end
        idle_cycles = moved ? 0 : idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        blk_valid   = 1'b0;
        blk_data    = '0;
        pix_stall   = 1'b0;
        errors      = 0;
        idle_cycles = 0;
        send_idle   = 1'b1;
        recv_idle   = 1'b1;
        hold_req    = 1'b0;
        cur_fixed   = 1'b0;
        cur_argb    = '0;

        // uniform blocks whose pixels can be read off directly
        add_row(8'd0, 8'd0, 48'h0, 16'h0000, 16'h0000, 32'h0, 9'd0, 9'd0, 1'b1, 32'h00000000);
        add_row(8'd255, 8'd255, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                9'd511, 9'd511, 1'b1, 32'hFFFFFFFF);
        add_row(8'd255, 8'd0, 48'h0, 16'hF800, 16'h0000, 32'h0, 9'd1, 9'd2, 1'b1,
                32'hFFFF0000);
        // six-level mode: selector 6 is zero, selector 7 is full
        add_row(8'd0, 8'd255, 48'hDB6_DB6_DB6_DB6, 16'h0000, 16'h07E0, 32'h5555_5555,
                9'd3, 9'd4, 1'b1, 32'h0000FF00);
        add_row(8'd0, 8'd0, 48'hFFFF_FFFF_FFFF, 16'h001F, 16'h0000, 32'h0, 9'd7, 9'd6, 1'b1,
                32'hFF0000FF);
        // every alpha selector in both modes, every colour selector
        add_row(8'd200, 8'd10, 48'hFAC688_FAC688, 16'h1234, 16'hFEDC, 32'hE4E4_E4E4,
                9'd5, 9'd9, 1'b0, '0);
        add_row(8'd10, 8'd200, 48'hFAC688_FAC688, 16'h1234, 16'hFEDC, 32'hE4E4_E4E4,
                9'd9, 9'd5, 1'b0, '0);
        add_row(8'd128, 8'd128, 48'hFAC688_FAC688, 16'hFEDC, 16'h1234, 32'h1B1B_1B1B,
                9'd100, 9'd200, 1'b0, '0);
        add_row(8'd101, 8'd100, 48'hFAC688_FAC688, 16'h7BEF, 16'h7BEF, 32'hE4E4_E4E4,
                9'd511, 9'd0, 1'b0, '0);
        add_row(8'd100, 8'd101, 48'hFAC688_FAC688, 16'h8410, 16'h7BEF, 32'hAAAA_AAAA,
                9'd0, 9'd511, 1'b0, '0);
        add_row(8'd255, 8'd0, 48'hFAC688_FAC688, 16'h0000, 16'hFFFF, 32'hE4E4_E4E4,
                9'd256, 9'd255, 1'b0, '0);
        add_row(8'd0, 8'd255, 48'hFAC688_FAC688, 16'hFFFF, 16'h0000, 32'h5555_5555,
                9'd255, 9'd256, 1'b0, '0);
        add_row(8'd1, 8'd0, 48'hFAC688_FAC688, 16'h0821, 16'hF7DE, 32'hE4E4_E4E4,
                9'd170, 9'd85, 1'b0, '0);
        add_row(8'd254, 8'd255, 48'hFAC688_FAC688, 16'hF7DE, 16'h0821, 32'h1B1B_1B1B,
                9'd85, 9'd170, 1'b0, '0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[r])
            send_block(dir_rows[r].blk, dir_rows[r].fixed, dir_rows[r].argb);

        for (int n = 0; n < 150; n++)
            send_block(random_block(), 1'b0, '0);

        // long hold on pix while blocks keep coming, then drain completely
        hold_req  = 1'b1;
        send_idle = 1'b0;
        for (int n = 0; n < 12; n++)
            send_block(random_block(), 1'b0, '0);
        blk_valid <= 1'b0;
        wait_drained();
        @(negedge clk);
        send_idle = 1'b1;

        for (int n = 0; n < 150; n++)
            send_block(random_block(), 1'b0, '0);

        // closing stretch at full rate on both sides
        send_idle = 1'b0;
        recv_idle = 1'b0;
        for (int n = 0; n < 90; n++)
            send_block(random_block(), 1'b0, '0);
        blk_valid <= 1'b0;

        wait_drained();
        repeat (40) @(posedge clk);
        if (errors == 0 && pixel_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
